[hdl/i2cmwr_pkg.sv]
// Package for the I2C master write-then-read sequencer.
// It holds the codes, widths and types that the sequencer modules share.
// It depends on nothing.
package i2cmwr_pkg;

    // Write buffer geometry.
    localparam int BUFFER_DEPTH = 16;
    localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // Field widths.
    localparam int POS_W = 5;
    localparam int CFG_W = 8;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_RESET  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    // Bus actions.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RACK  = 3'd3,
        ACT_RNACK = 3'd4,
        ACT_STOP  = 3'd5,
        ACT_RESET = 3'd6,
        ACT_CLEAR = 3'd7
    } t_act;

    // Bus modes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BUSY = 2'd1,
        MODE_MT   = 2'd2,
        MODE_MR   = 2'd3
    } t_mode;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_REFUSED  = 3'd1,
        ERR_NOTHING  = 3'd2,
        ERR_SHORT    = 3'd3,
        ERR_BUS      = 3'd4,
        ERR_UNKNOWN  = 3'd5
    } t_err;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_WADDR = 2'd0,
        CFG_RADDR = 2'd1,
        CFG_WLEN  = 2'd2,
        CFG_RLEN  = 2'd3
    } t_cfg_idx;

    // Bus status codes with the prescaler bits masked off.
    localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    // Result word; tx_mem marks a transmit byte that comes from the buffer read.
    typedef struct packed {
        t_act       act;
        logic [7:0] tx;
        logic       tx_mem;
        t_mode      mode;
        logic       rvalid;
        logic [3:0] ridx;
        logic [7:0] rbyte;
        logic       done;
        t_err       err;
    } t_result;

    // Buffer access request from the sequencer.
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } t_buf_req;

endpackage

[hdl/i2cmwr_wbuf.sv]
// Write buffer of the sequencer: one synchronous memory, one write and one
// registered read port. It depends on i2cmwr_pkg.
module i2cmwr_wbuf (
    input  logic                 i_clk,
    input  i2cmwr_pkg::t_buf_req i_req,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [i2cmwr_pkg::BUFFER_DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port; the data word holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/i2cmwr_ctrl.sv]
// Sequencer core: mode and position registers and the decode of each word.
// It issues buffer accesses and forms the result. It depends on i2cmwr_pkg.
module i2cmwr_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_operation,
    input  logic [7:0]                     i_bus_status,
    input  logic [7:0]                     i_received_byte,
    input  logic [3:0]                     i_load_index,
    input  logic [7:0]                     i_load_byte,
    input  logic [7:0]                     i_waddr_byte,
    input  logic [7:0]                     i_raddr_byte,
    input  logic [i2cmwr_pkg::POS_W-1:0]   i_wlen,
    input  logic [i2cmwr_pkg::POS_W-1:0]   i_rlen,
    output i2cmwr_pkg::t_result            o_result,
    output i2cmwr_pkg::t_buf_req           o_buf_req
);

    i2cmwr_pkg::t_mode               r_mode, n_mode;
    logic [i2cmwr_pkg::POS_W-1:0]    r_wpos, n_wpos;
    logic [i2cmwr_pkg::POS_W-1:0]    r_rpos, n_rpos;
    logic [i2cmwr_pkg::POS_W-1:0]    rpos_inc;
    logic [7:0]                      status;
    i2cmwr_pkg::t_result             res;
    i2cmwr_pkg::t_buf_req            req;

    assign status   = {i_bus_status[7:3], 3'b000};
    assign rpos_inc = r_rpos + i2cmwr_pkg::POS_W'(1);

    // Decode of one word into the next state, the result and buffer accesses.
    always_comb begin
        n_mode     = r_mode;
        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        res        = '0;
        res.act    = i2cmwr_pkg::ACT_NONE;
        res.err    = i2cmwr_pkg::ERR_NONE;
        req        = '0;
        req.waddr  = i2cmwr_pkg::BUF_AW'(i_load_index);
        req.wdata  = i_load_byte;
        req.raddr  = i2cmwr_pkg::BUF_AW'(r_wpos);
        case (i2cmwr_pkg::t_op'(i_operation))
            i2cmwr_pkg::OP_LOAD: begin
                req.we = (32'(i_load_index) < i2cmwr_pkg::BUFFER_DEPTH);
            end
            i2cmwr_pkg::OP_START: begin
                if (r_mode == i2cmwr_pkg::MODE_IDLE) begin
                    n_mode  = i2cmwr_pkg::MODE_BUSY;
                    res.act = i2cmwr_pkg::ACT_START;
                end else begin
                    res.err = i2cmwr_pkg::ERR_REFUSED;
                end
            end
            i2cmwr_pkg::OP_RESET: begin
                n_mode  = i2cmwr_pkg::MODE_BUSY;
                res.act = i2cmwr_pkg::ACT_RESET;
            end
            default: begin
                case (status) inside
                    i2cmwr_pkg::ST_START, i2cmwr_pkg::ST_RSTART: begin
                        if (r_wpos == '0 && i_wlen != '0) begin
                            n_mode  = i2cmwr_pkg::MODE_MT;
                            res.tx  = i_waddr_byte;
                            res.act = i2cmwr_pkg::ACT_SEND;
                        end else if (r_rpos == '0 && i_rlen != '0) begin
                            n_mode  = i2cmwr_pkg::MODE_MR;
                            res.tx  = i_raddr_byte;
                            res.act = i2cmwr_pkg::ACT_SEND;
                        end else begin
                            res.err = i2cmwr_pkg::ERR_NOTHING;
                        end
                    end
                    i2cmwr_pkg::ST_SLA_W_ACK: begin
                        // First data byte comes from buffer entry zero.
                        req.re     = 1'b1;
                        req.raddr  = '0;
                        res.tx_mem = 1'b1;
                        n_wpos     = i2cmwr_pkg::POS_W'(1);
                        res.act    = i2cmwr_pkg::ACT_SEND;
                    end
                    i2cmwr_pkg::ST_SLA_W_NACK, i2cmwr_pkg::ST_DATA_NACK,
                    i2cmwr_pkg::ST_ARB_LOST, i2cmwr_pkg::ST_SLA_R_NACK: begin
                        n_wpos  = '0;
                        n_rpos  = '0;
                        n_mode  = i2cmwr_pkg::MODE_BUSY;
                        res.act = i2cmwr_pkg::ACT_START;
                    end
                    i2cmwr_pkg::ST_DATA_ACK: begin
                        if (r_wpos == i_wlen) begin
                            n_mode  = i2cmwr_pkg::MODE_BUSY;
                            res.act = i2cmwr_pkg::ACT_START;
                        end else begin
                            // Positions past the buffer send a zero byte.
                            req.re     = (32'(r_wpos) < i2cmwr_pkg::BUFFER_DEPTH);
                            res.tx_mem = req.re;
                            n_wpos     = r_wpos + i2cmwr_pkg::POS_W'(1);
                            res.act    = i2cmwr_pkg::ACT_SEND;
                        end
                    end
                    i2cmwr_pkg::ST_SLA_R_ACK: begin
                        res.act = i2cmwr_pkg::ACT_SEND;
                    end
                    i2cmwr_pkg::ST_RX_ACK: begin
                        res.rvalid = 1'b1;
                        res.ridx   = r_rpos[3:0];
                        res.rbyte  = i_received_byte;
                        n_rpos     = rpos_inc;
                        if (i_rlen != '0 && rpos_inc == i_rlen - i2cmwr_pkg::POS_W'(1)) begin
                            res.act = i2cmwr_pkg::ACT_RNACK;
                        end else if (rpos_inc >= i_rlen) begin
                            n_mode   = i2cmwr_pkg::MODE_IDLE;
                            res.act  = i2cmwr_pkg::ACT_STOP;
                            res.done = 1'b1;
                        end else begin
                            res.act = i2cmwr_pkg::ACT_RACK;
                        end
                    end
                    i2cmwr_pkg::ST_RX_NACK: begin
                        res.rvalid = 1'b1;
                        res.ridx   = r_rpos[3:0];
                        res.rbyte  = i_received_byte;
                        if (rpos_inc != i_rlen) begin
                            // Short read: the mode stays as it is.
                            n_rpos  = '0;
                            n_wpos  = '0;
                            res.act = i2cmwr_pkg::ACT_RESET;
                            res.err = i2cmwr_pkg::ERR_SHORT;
                        end else begin
                            n_rpos   = rpos_inc;
                            n_mode   = i2cmwr_pkg::MODE_IDLE;
                            res.act  = i2cmwr_pkg::ACT_STOP;
                            res.done = 1'b1;
                        end
                    end
                    i2cmwr_pkg::ST_BUS_ERROR: begin
                        n_mode  = i2cmwr_pkg::MODE_IDLE;
                        res.act = i2cmwr_pkg::ACT_STOP;
                        res.err = i2cmwr_pkg::ERR_BUS;
                    end
                    default: begin
                        res.act = i2cmwr_pkg::ACT_CLEAR;
                        res.err = i2cmwr_pkg::ERR_UNKNOWN;
                    end
                endcase
            end
        endcase
        res.mode = n_mode;
        if (!i_accept) begin
            req.we = 1'b0;
            req.re = 1'b0;
        end
    end

    // State registers advance only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= i2cmwr_pkg::MODE_IDLE;
            r_wpos <= '0;
            r_rpos <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_wpos <= n_wpos;
            r_rpos <= n_rpos;
        end
    end

    assign o_result  = res;
    assign o_buf_req = req;

endmodule

[hdl/i2c_master_write_read_sequencer_unit.sv]
// I2C master write-then-read sequencer, top level.
// It holds the configuration registers, the result pipeline and the output
// register; it depends on i2cmwr_pkg, i2cmwr_ctrl and i2cmwr_wbuf.
//
// Usage: each input word (load, start, reset or bus status event) gives
// exactly one result word with the next bus action, the byte to transmit,
// the mode, any received byte with its index, a done flag and an error code.
// Input channel: i_in_valid / o_in_stall; output channel: o_out_valid /
// i_out_stall. A word moves when valid is high and stall is low.
// A result passes the buffer read stage (synchronous read), then the output
// register. Throughput is one word per cycle while the output is not stalled;
// the sequencer updates its mode and positions in the acceptance cycle, so
// words may follow back to back. When the receiver stalls, the result holds
// in the output register and the pipeline stage behind it still takes one
// more word before o_in_stall rises. Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_wdata while the block is idle, a rule for
// the user that the block does not enforce. A synchronous active-low reset
// empties the pipeline, sets the mode to idle, clears both positions and
// loads the register defaults; the buffer contents are undefined until loaded.
module i2c_master_write_read_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_received_byte,
    input  logic [3:0]  i_load_index,
    input  logic [7:0]  i_load_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_bus_action,
    output logic [7:0]  o_transmit_byte,
    output logic [1:0]  o_bus_mode,
    output logic        o_read_valid,
    output logic [3:0]  o_read_index,
    output logic [7:0]  o_read_byte,
    output logic        o_transfer_done,
    output logic [2:0]  o_error_code
);

    logic [7:0]                    r_waddr_byte;
    logic [7:0]                    r_raddr_byte;
    logic [i2cmwr_pkg::POS_W-1:0]  r_wlen;
    logic [i2cmwr_pkg::POS_W-1:0]  r_rlen;
    logic                          in_acc;
    logic                          s1_adv;
    logic                          r_s1_valid;
    i2cmwr_pkg::t_result           r_s1;
    i2cmwr_pkg::t_result           n_s1;
    i2cmwr_pkg::t_result           s1_word;
    i2cmwr_pkg::t_buf_req          buf_req;
    logic [7:0]                    buf_rdata;
    logic                          r_out_valid;
    i2cmwr_pkg::t_result           r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr_byte <= 8'd0;
            r_raddr_byte <= 8'd1;
            r_wlen       <= '0;
            r_rlen       <= '0;
        end else if (i_cfg_we) begin
            case (i2cmwr_pkg::t_cfg_idx'(i_cfg_index))
                i2cmwr_pkg::CFG_WADDR: r_waddr_byte <= i_cfg_wdata;
                i2cmwr_pkg::CFG_RADDR: r_raddr_byte <= i_cfg_wdata;
                i2cmwr_pkg::CFG_WLEN:  r_wlen <= i_cfg_wdata[i2cmwr_pkg::POS_W-1:0];
                i2cmwr_pkg::CFG_RLEN:  r_rlen <= i_cfg_wdata[i2cmwr_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the buffer read stage moves on when the output register frees.
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    i2cmwr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_acc),
        .i_operation     (i_operation),
        .i_bus_status    (i_bus_status),
        .i_received_byte (i_received_byte),
        .i_load_index    (i_load_index),
        .i_load_byte     (i_load_byte),
        .i_waddr_byte    (r_waddr_byte),
        .i_raddr_byte    (r_raddr_byte),
        .i_wlen          (r_wlen),
        .i_rlen          (r_rlen),
        .o_result        (n_s1),
        .o_buf_req       (buf_req)
    );

    i2cmwr_wbuf u_wbuf (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_rdata)
    );

    // Buffer read stage: the result waits here for the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Merge the buffer byte into the result word.
    always_comb begin
        s1_word    = r_s1;
        s1_word.tx = r_s1.tx_mem ? buf_rdata : r_s1.tx;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= s1_word;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bus_action    = r_out.act;
    assign o_transmit_byte = r_out.tx;
    assign o_bus_mode      = r_out.mode;
    assign o_read_valid    = r_out.rvalid;
    assign o_read_index    = r_out.ridx;
    assign o_read_byte     = r_out.rbyte;
    assign o_transfer_done = r_out.done;
    assign o_error_code    = r_out.err;

    // An accepted word always occupies the buffer read stage next cycle.
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word did not enter the read stage");

    // The input stalls only while the read stage holds a word that cannot move.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A word in the read stage that moves lands in the output register.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("result lost between read stage and output");

    // A completed transfer leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |->
            (r_out.mode == i2cmwr_pkg::MODE_IDLE && r_out.act == i2cmwr_pkg::ACT_STOP))
        else $error("transfer done without stop in idle mode");

endmodule

[sim/i2c_master_write_read_sequencer_unit_test.sv]
// Self-checking bench for the I2C master write-then-read sequencer.
// It drives load, start, reset and bus status words, predicts each result word and checks it.
// It depends on i2cmwr_pkg and i2c_master_write_read_sequencer_unit.
module i2c_master_write_read_sequencer_unit_test;
    import i2cmwr_pkg::*;

    // One input word and one result word, at the widths of the ports.
    typedef struct packed {
        t_op        op;
        logic [7:0] status;
        logic [7:0] rx;
        logic [3:0] lidx;
        logic [7:0] lbyte;
    } t_word;

    typedef struct packed {
        t_act       act;
        logic [7:0] tx;
        t_mode      mode;
        logic       rvalid;
        logic [3:0] ridx;
        logic [7:0] rbyte;
        logic       done;
        t_err       err;
    } t_bus_result;

    // Tracks the sequencer state, works out the result of each accepted word and
    // compares the results that come out against it in order.
    class seq_tracker;
        logic [7:0]  waddr_byte = 8'h00;
        logic [7:0]  raddr_byte = 8'h01;
        logic [4:0]  wr_len     = 5'd0;
        logic [4:0]  rd_len     = 5'd0;
        t_mode       cur_mode   = MODE_IDLE;
        logic [4:0]  wr_pos     = 5'd0;
        logic [4:0]  rd_pos     = 5'd0;
        logic [7:0]  wr_buf [BUFFER_DEPTH];
        bit          loaded [BUFFER_DEPTH];
        t_act        last_act    = ACT_NONE;
        logic [7:0]  last_status = 8'h00;
        t_bus_result due_results [$];
        int          fails = 0;

        function void set_reg(t_cfg_idx idx, logic [7:0] v);
            case (idx)
                CFG_WADDR: waddr_byte = v;
                CFG_RADDR: raddr_byte = v;
                CFG_WLEN:  wr_len = v[4:0];
                CFG_RLEN:  rd_len = v[4:0];
                default: ;
            endcase
        endfunction

        // Positions past the end of the buffer send zero.
        function logic [7:0] byte_at(logic [4:0] pos);
            if (pos < BUFFER_DEPTH) return wr_buf[pos[3:0]];
            return 8'h00;
        endfunction

        function void note_word(t_word w);
            t_bus_result r;
            logic [7:0]  st;
            r = '0;
            st = {w.status[7:3], 3'b000};
            case (w.op)
                OP_LOAD: begin
                    wr_buf[w.lidx] = w.lbyte;
                    loaded[w.lidx] = 1'b1;
                end
                OP_START: begin
                    if (cur_mode == MODE_IDLE) begin
                        cur_mode = MODE_BUSY;
                        r.act = ACT_START;
                    end else begin
                        r.err = ERR_REFUSED;
                    end
                end
                OP_RESET: begin
                    cur_mode = MODE_BUSY;
                    r.act = ACT_RESET;
                end
                default: begin
                    case (st)
                        ST_START, ST_RSTART: begin
                            if (wr_pos == 5'd0 && wr_len != 5'd0) begin
                                cur_mode = MODE_MT;
                                r.tx = waddr_byte;
                                r.act = ACT_SEND;
                            end else if (rd_pos == 5'd0 && rd_len != 5'd0) begin
                                cur_mode = MODE_MR;
                                r.tx = raddr_byte;
                                r.act = ACT_SEND;
                            end else begin
                                r.err = ERR_NOTHING;
                            end
                        end
                        ST_SLA_W_ACK: begin
                            r.tx = byte_at(5'd0);
                            wr_pos = 5'd1;
                            r.act = ACT_SEND;
                        end
                        // Any refusal or lost arbitration starts the transaction again.
                        ST_SLA_W_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_SLA_R_NACK: begin
                            wr_pos = 5'd0;
                            rd_pos = 5'd0;
                            cur_mode = MODE_BUSY;
                            r.act = ACT_START;
                        end
                        ST_DATA_ACK: begin
                            if (wr_pos == wr_len) begin
                                cur_mode = MODE_BUSY;
                                r.act = ACT_START;
                            end else begin
                                r.tx = byte_at(wr_pos);
                                wr_pos = wr_pos + 5'd1;
                                r.act = ACT_SEND;
                            end
                        end
                        ST_SLA_R_ACK: r.act = ACT_SEND;
                        ST_RX_ACK: begin
                            r.rvalid = 1'b1;
                            r.ridx = rd_pos[3:0];
                            r.rbyte = w.rx;
                            rd_pos = rd_pos + 5'd1;
                            if (rd_len != 5'd0 && rd_pos == rd_len - 5'd1) begin
                                r.act = ACT_RNACK;
                            end else if (rd_pos >= rd_len) begin
                                cur_mode = MODE_IDLE;
                                r.act = ACT_STOP;
                                r.done = 1'b1;
                            end else begin
                                r.act = ACT_RACK;
                            end
                        end
                        ST_RX_NACK: begin
                            r.rvalid = 1'b1;
                            r.ridx = rd_pos[3:0];
                            r.rbyte = w.rx;
                            rd_pos = rd_pos + 5'd1;
                            // A last byte at the wrong count is a short read.
                            if (rd_pos != rd_len) begin
                                rd_pos = 5'd0;
                                wr_pos = 5'd0;
                                r.act = ACT_RESET;
                                r.err = ERR_SHORT;
                            end else begin
                                cur_mode = MODE_IDLE;
                                r.act = ACT_STOP;
                                r.done = 1'b1;
                            end
                        end
                        ST_BUS_ERROR: begin
                            cur_mode = MODE_IDLE;
                            r.act = ACT_STOP;
                            r.err = ERR_BUS;
                        end
                        default: begin
                            r.act = ACT_CLEAR;
                            r.err = ERR_UNKNOWN;
                        end
                    endcase
                end
            endcase
            r.mode = cur_mode;
            last_act = r.act;
            last_status = st;
            due_results.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_result(t_bus_result got);
            t_bus_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result word with no input word outstanding", $time);
                fails++;
                return;
            end
            want = due_results.pop_front();
            cmp_field("bus_action", want.act, got.act);
            cmp_field("transmit_byte", want.tx, got.tx);
            cmp_field("bus_mode", want.mode, got.mode);
            cmp_field("read_valid", want.rvalid, got.rvalid);
            cmp_field("read_index", want.ridx, got.ridx);
            cmp_field("read_byte", want.rbyte, got.rbyte);
            cmp_field("transfer_done", want.done, got.done);
            cmp_field("error_code", want.err, got.err);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_operation;
    logic [7:0] i_bus_status;
    logic [7:0] i_received_byte;
    logic [3:0] i_load_index;
    logic [7:0] i_load_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_bus_action;
    logic [7:0] o_transmit_byte;
    logic [1:0] o_bus_mode;
    logic       o_read_valid;
    logic [3:0] o_read_index;
    logic [7:0] o_read_byte;
    logic       o_transfer_done;
    logic [2:0] o_error_code;

    seq_tracker trk;
    bit         send_quiet = 1'b0;
    bit         recv_quiet = 1'b0;
    int         stall_left = 0;

    i2c_master_write_read_sequencer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_bus_status    (i_bus_status),
        .i_received_byte (i_received_byte),
        .i_load_index    (i_load_index),
        .i_load_byte     (i_load_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bus_action    (o_bus_action),
        .o_transmit_byte (o_transmit_byte),
        .o_bus_mode      (o_bus_mode),
        .o_read_valid    (o_read_valid),
        .o_read_index    (o_read_index),
        .o_read_byte     (o_read_byte),
        .o_transfer_done (o_transfer_done),
        .o_error_code    (o_error_code)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hang.
    initial begin
        #5000000;
        $display("** i2c_master_write_read_sequencer_unit: FAILED **");
        $finish;
    end

    // Result side stall: a fresh count of stalled cycles after every result taken.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result monitor, sampling at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            trk.check_result('{t_act'(o_bus_action), o_transmit_byte, t_mode'(o_bus_mode),
                               o_read_valid, o_read_index, o_read_byte, o_transfer_done,
                               t_err'(o_error_code)});
            if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
            stall_left = recv_quiet ? 0 : $urandom_range(0, 19);
        end
    end

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_word dword(t_op op, logic [7:0] st, logic [7:0] rx,
                                    logic [3:0] idx, logic [7:0] b);
        t_word w;
        w.op = op;
        w.status = st;
        w.rx = rx;
        w.lidx = idx;
        w.lbyte = b;
        return w;
    endfunction

    // Picks the next word. Mostly it answers the last bus action as a well-behaved
    // bus would; the rest is loads and arbitrary words.
    function automatic t_word next_word();
        t_word      w;
        logic [7:0] st;
        int         roll;
        int         need;
        w = dword(OP_STATUS, 8'h00, 8'($urandom), 4'($urandom), 8'($urandom));
        st = ST_START;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            w.op = OP_LOAD;
        end else if (roll < 18) begin
            w.op = t_op'($urandom_range(0, 3));
            st = 8'($urandom) & 8'hF8;
        end else begin
            case (trk.last_act)
                ACT_START: begin
                    if (chance(12)) st = ST_ARB_LOST;
                    else st = chance(50) ? ST_START : ST_RSTART;
                end
                ACT_SEND: begin
                    if (trk.last_status == ST_START || trk.last_status == ST_RSTART) begin
                        if (trk.cur_mode == MODE_MR) st = chance(10) ? ST_SLA_R_NACK : ST_SLA_R_ACK;
                        else st = chance(10) ? ST_SLA_W_NACK : ST_SLA_W_ACK;
                    end else if (trk.cur_mode == MODE_MR) begin
                        st = ((trk.rd_len > 5'd1) ^ chance(10)) ? ST_RX_ACK : ST_RX_NACK;
                    end else begin
                        st = chance(12) ? ST_DATA_NACK : ST_DATA_ACK;
                    end
                end
                ACT_RACK:  st = chance(10) ? ST_RX_NACK : ST_RX_ACK;
                ACT_RNACK: st = chance(10) ? ST_RX_ACK : ST_RX_NACK;
                default: begin
                    // Stuck with nothing pending: the bus starts over or drops out.
                    if (trk.cur_mode == MODE_IDLE) begin
                        w.op = OP_START;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: st = ST_START;
                            1: st = ST_ARB_LOST;
                            2: st = ST_BUS_ERROR;
                            default: st = ST_SLA_W_NACK;
                        endcase
                    end
                end
            endcase
        end
        // A buffer entry that was never loaded must not be sent; load it instead.
        if (w.op == OP_STATUS) begin
            need = -1;
            if (st == ST_SLA_W_ACK) begin
                need = 0;
            end else if (st == ST_DATA_ACK && trk.wr_pos != trk.wr_len
                         && trk.wr_pos < BUFFER_DEPTH) begin
                need = trk.wr_pos;
            end
            if (need >= 0 && !trk.loaded[need]) begin
                w.op = OP_LOAD;
                w.lidx = 4'(need);
            end
        end
        w.status = st | 8'($urandom_range(0, 7));
        return w;
    endfunction

    // Offers one word after a random gap and notes it once it is taken.
    task automatic push_word(t_word w);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= w.op;
        i_bus_status <= w.status;
        i_received_byte <= w.rx;
        i_load_index <= w.lidx;
        i_load_byte <= w.lbyte;
        do @(posedge i_clk); while (o_in_stall);
        trk.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        trk.set_reg(idx, v);
    endtask

    // Waits until every result has come back and the pipeline has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (trk.due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        int ph;
        int n;
        trk = new;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WADDR;
        i_cfg_wdata = 8'h00;
        i_in_valid = 1'b0;
        i_operation = OP_LOAD;
        i_bus_status = 8'h00;
        i_received_byte = 8'h00;
        i_load_index = 4'h0;
        i_load_byte = 8'h00;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: idle corner cases and a read with zero length.
        push_word(dword(OP_STATUS, ST_START, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_START, 8'h00, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_START, 8'h00, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, 8'hFF, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, 8'h07, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_RESET, 8'h00, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_RX_ACK, 8'hFF, 4'h0, 8'h00));
        push_word(dword(OP_LOAD, 8'h00, 8'h00, 4'h0, 8'hA5));
        push_word(dword(OP_LOAD, 8'h00, 8'h00, 4'hF, 8'hFF));
        push_word(dword(OP_LOAD, 8'h00, 8'h00, 4'h1, 8'h00));
        drain();

        // A full two-byte write then two-byte read, with restarts and a short read.
        write_reg(CFG_WADDR, 8'hA0);
        write_reg(CFG_RADDR, 8'hA1);
        write_reg(CFG_WLEN, 8'd2);
        write_reg(CFG_RLEN, 8'd2);
        push_word(dword(OP_STATUS, ST_ARB_LOST, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_START, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_SLA_W_NACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_START, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_SLA_W_ACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_DATA_ACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_DATA_ACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_RSTART, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_SLA_R_ACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_RX_ACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_RX_NACK, 8'hFF, 4'h0, 8'h00));
        push_word(dword(OP_START, 8'h00, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_START, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_SLA_R_NACK, 8'h00, 4'h0, 8'h00));
        push_word(dword(OP_STATUS, ST_RX_NACK, 8'h5A, 4'h0, 8'h00));

        // Random traffic over several register settings, extremes first.
        for (ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(CFG_WADDR, 8'hFF);
                    write_reg(CFG_RADDR, 8'h00);
                    write_reg(CFG_WLEN, 8'd16);
                    write_reg(CFG_RLEN, 8'd16);
                end
                1: begin
                    write_reg(CFG_WLEN, 8'd0);
                    write_reg(CFG_RLEN, 8'd0);
                end
                2: begin
                    write_reg(CFG_WLEN, 8'd0);
                    write_reg(CFG_RLEN, 8'd16);
                end
                3: begin
                    write_reg(CFG_WLEN, 8'd16);
                    write_reg(CFG_RLEN, 8'd0);
                end
                4: begin
                    write_reg(CFG_WLEN, 8'd1);
                    write_reg(CFG_RLEN, 8'd1);
                end
                default: begin
                    write_reg(CFG_WADDR, 8'($urandom));
                    write_reg(CFG_RADDR, 8'($urandom));
                    write_reg(CFG_WLEN, 8'($urandom_range(0, 16)));
                    write_reg(CFG_RLEN, 8'($urandom_range(0, 16)));
                end
            endcase
            for (n = 0; n < 125; n++) begin
                if (n % 40 == 0) send_quiet = chance(30);
                push_word(next_word());
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (trk.fails == 0) begin
            $display("** i2c_master_write_read_sequencer_unit: PASSED **");
        end else begin
            $display("** i2c_master_write_read_sequencer_unit: FAILED **");
        end
        $finish;
    end
endmodule
